@@ src/cgl_pkg.sv @@
// Shared types and constants for the colour grading LUT entry generator.
// Widths, fixed point constants, register codes and the lane config struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cgl_pkg;

   // grid geometry
   localparam int MAX_GRID_SIZE = 64;
   localparam int IDX_W         = 6;
   localparam int GRID_W        = 7;
   localparam int SIZE_W        = $clog2(MAX_GRID_SIZE + 1);
   localparam int LAST_W        = $clog2(MAX_GRID_SIZE);
   localparam int CMP_W         = (IDX_W > LAST_W) ? IDX_W : LAST_W;
   localparam int CMPG_W        = GRID_W + SIZE_W;

   // fixed point, Q.12 with 4096 = 1.0
   localparam int FRAC_W    = 12;
   localparam int CH_W      = FRAC_W + 1;
   localparam int GAIN_W    = 16;
   localparam int CH_ONE    = 4096;
   localparam int MID_GREY  = 2048;

   // reciprocal of (size - 1), exact for every index on the grid
   localparam int RECIP_SHIFT = FRAC_W + 2 * LAST_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // luma weights, sum 4096
   localparam int LUMA_R = 871;
   localparam int LUMA_G = 2929;
   localparam int LUMA_B = 296;
   localparam int LUMA_W = 2 * FRAC_W + 1;

   // result fields
   localparam int OUT_W   = 16;
   localparam int ENTRY_W = 18;
   localparam int OUT_MAX = 32767;
   localparam int OUT_MIN = -32768;

   // lanes and pipeline depth
   localparam int LANES       = 3;
   localparam int LANE_STAGES = 5;
   localparam int PIPE_STAGES = 8;

   // stream and register port widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [GRID_W-1:0] GRID_RESET = 7'd33;
   localparam logic [GAIN_W-1:0] GAIN_ONE   = 16'd4096;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_SIZE  = 2'd0,
      REG_EXPOSURE   = 2'd1,
      REG_CONTRAST   = 2'd2,
      REG_SATURATION = 2'd3
   } csr_reg_type;

   // settings every lane needs
   typedef struct packed {
      logic [LAST_W-1:0]  last;
      logic [RECIP_W-1:0] recip;
      logic [GAIN_W-1:0]  exposure;
      logic [GAIN_W-1:0]  contrast;
   } lane_cfg_type;

endpackage

`default_nettype wire

@@ src/cgl_lane.sv @@
// One colour channel lane: index clamp, normalise, exposure, contrast, clamp.
// Five register stages, advanced by per-stage enables. Depends on cgl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgl_lane (
   input  wire logic                                clock,
   input  wire logic [cgl_pkg::LANE_STAGES-1:0]     stage_en,
   input  wire cgl_pkg::lane_cfg_type               cfg,
   input  wire logic [cgl_pkg::IDX_W-1:0]           index_in,
   output logic      [cgl_pkg::CH_W-1:0]            chan_out,
   output logic      [cgl_pkg::IDX_W-1:0]           index_out
);

   localparam int NPROD_W = cgl_pkg::IDX_W + cgl_pkg::RECIP_W;
   localparam int EPROD_W = cgl_pkg::CH_W + cgl_pkg::GAIN_W;
   localparam int EXPO_W  = EPROD_W - cgl_pkg::FRAC_W;
   localparam int CPROD_W = EXPO_W + cgl_pkg::GAIN_W + 2;
   localparam int CSUM_W  = CPROD_W - cgl_pkg::FRAC_W + 1;

   logic [cgl_pkg::IDX_W-1:0]  idx_ff [cgl_pkg::LANE_STAGES];
   logic [cgl_pkg::IDX_W-1:0]  idx_clamp;
   logic [NPROD_W-1:0]         nprod_ff;
   logic [cgl_pkg::CH_W-1:0]   norm;
   logic [EPROD_W-1:0]         eprod_ff;
   logic [EXPO_W-1:0]          expo;
   logic signed [EXPO_W:0]     centred;
   logic signed [CPROD_W-1:0]  cprod_ff;
   logic signed [CSUM_W-1:0]   csum;
   logic [cgl_pkg::CH_W-1:0]   chan_in;
   logic [cgl_pkg::CH_W-1:0]   chan_ff;

   function automatic logic [cgl_pkg::CMP_W-1:0] CMP_W_ext(logic [cgl_pkg::IDX_W-1:0] v);
      return cgl_pkg::CMP_W'(v);
   endfunction

   function automatic logic [cgl_pkg::CMP_W-1:0] CMP_W_ext_last(
      logic [cgl_pkg::LAST_W-1:0] v);
      return cgl_pkg::CMP_W'(v);
   endfunction

   // clamp the index to the last grid position
   always_comb begin
      if (CMP_W_ext(index_in) > CMP_W_ext_last(cfg.last)) begin
         idx_clamp = cgl_pkg::IDX_W'(cfg.last);
      end else begin
         idx_clamp = index_in;
      end
   end

   // normalise: index * 4096 / (size - 1) through the reciprocal
   assign norm = cgl_pkg::CH_W'(nprod_ff >> (cgl_pkg::RECIP_SHIFT - cgl_pkg::FRAC_W));

   // exposure result and offset about mid grey
   assign expo    = eprod_ff[EPROD_W-1:cgl_pkg::FRAC_W];
   assign centred = $signed({1'b0, expo}) - $signed((EXPO_W + 1)'(cgl_pkg::MID_GREY));

   // contrast result, floored, back about mid grey, clamped to [0, 1.0]
   always_comb begin
      csum = CSUM_W'($signed(cprod_ff[CPROD_W-1:cgl_pkg::FRAC_W]))
           + $signed(CSUM_W'(cgl_pkg::MID_GREY));
      if (csum < 0) begin
         chan_in = '0;
      end else if (csum > $signed(CSUM_W'(cgl_pkg::CH_ONE))) begin
         chan_in = cgl_pkg::CH_W'(cgl_pkg::CH_ONE);
      end else begin
         chan_in = cgl_pkg::CH_W'(csum);
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         idx_ff[0] <= idx_clamp;
      end
      for (int k = 1; k < cgl_pkg::LANE_STAGES; k++) begin
         if (stage_en[k]) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
      if (stage_en[1]) begin
         nprod_ff <= NPROD_W'(idx_ff[0]) * NPROD_W'(cfg.recip);
      end
      if (stage_en[2]) begin
         eprod_ff <= EPROD_W'(norm) * EPROD_W'(cfg.exposure);
      end
      if (stage_en[3]) begin
         cprod_ff <= CPROD_W'(centred) * CPROD_W'($signed({1'b0, cfg.contrast}));
      end
      if (stage_en[4]) begin
         chan_ff <= chan_in;
      end
   end

   assign chan_out  = chan_ff;
   assign index_out = idx_ff[cgl_pkg::LANE_STAGES-1];

endmodule

`default_nettype wire

@@ src/cgl_merge.sv @@
// Merging stage: luma, saturation about luma, output saturation, entry number.
// Three register stages fed by the three channel lanes. Depends on cgl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgl_merge (
   input  wire logic                                                 clock,
   input  wire logic [cgl_pkg::PIPE_STAGES-cgl_pkg::LANE_STAGES-1:0] stage_en,
   input  wire logic [cgl_pkg::SIZE_W-1:0]                           size,
   input  wire logic [cgl_pkg::GAIN_W-1:0]                           saturation,
   input  wire logic [cgl_pkg::LANES-1:0][cgl_pkg::CH_W-1:0]         chan_in,
   input  wire logic [cgl_pkg::LANES-1:0][cgl_pkg::IDX_W-1:0]        index_in,
   output logic      [cgl_pkg::LANES-1:0][cgl_pkg::OUT_W-1:0]        colour_out,
   output logic      [cgl_pkg::ENTRY_W-1:0]                          entry_out
);

   localparam int DIFF_W  = cgl_pkg::LUMA_W + 1;
   localparam int SPROD_W = DIFF_W + cgl_pkg::GAIN_W + 1;
   localparam int TOTAL_W = SPROD_W + 1;
   localparam int SHIFT   = 2 * cgl_pkg::FRAC_W;
   localparam int SCALE_W = TOTAL_W - SHIFT;
   localparam int ROW_W   = cgl_pkg::IDX_W + cgl_pkg::SIZE_W + 1;
   localparam int LIN_W   = ROW_W + cgl_pkg::SIZE_W + 1;

   logic [cgl_pkg::LUMA_W-1:0]                    luma_sum;
   logic [cgl_pkg::LUMA_W-1:0]                    luma_ff;
   logic [cgl_pkg::LUMA_W-1:0]                    luma7_ff;
   logic [cgl_pkg::LANES-1:0][cgl_pkg::CH_W-1:0]  chan6_ff;
   logic [cgl_pkg::IDX_W-1:0]                     red_idx6_ff;
   logic [ROW_W-1:0]                              row_ff;
   logic [LIN_W-1:0]                              lin;
   logic [cgl_pkg::ENTRY_W-1:0]                   entry7_ff;
   logic [cgl_pkg::ENTRY_W-1:0]                   entry_ff;
   logic signed [DIFF_W-1:0]                      diff [cgl_pkg::LANES];
   logic signed [SPROD_W-1:0]                     sprod_ff [cgl_pkg::LANES];
   logic signed [TOTAL_W-1:0]                     total [cgl_pkg::LANES];
   logic signed [SCALE_W-1:0]                     scaled [cgl_pkg::LANES];
   logic [cgl_pkg::LANES-1:0][cgl_pkg::OUT_W-1:0] colour_in;
   logic [cgl_pkg::LANES-1:0][cgl_pkg::OUT_W-1:0] colour_ff;

   // luma scaled by 4096
   assign luma_sum = cgl_pkg::LUMA_W'(chan_in[0]) * cgl_pkg::LUMA_W'(cgl_pkg::LUMA_R)
                   + cgl_pkg::LUMA_W'(chan_in[1]) * cgl_pkg::LUMA_W'(cgl_pkg::LUMA_G)
                   + cgl_pkg::LUMA_W'(chan_in[2]) * cgl_pkg::LUMA_W'(cgl_pkg::LUMA_B);

   // second half of the entry number
   assign lin = LIN_W'(row_ff) * LIN_W'(size) + LIN_W'(red_idx6_ff);

   // channel distance from luma, then push and floor back to Q.12
   always_comb begin
      for (int k = 0; k < cgl_pkg::LANES; k++) begin
         diff[k] = $signed(DIFF_W'({chan6_ff[k], cgl_pkg::FRAC_W'(0)}))
                 - $signed(DIFF_W'(luma_ff));
         total[k] = $signed(TOTAL_W'({luma7_ff, cgl_pkg::FRAC_W'(0)}))
                  + TOTAL_W'(sprod_ff[k]);
         scaled[k] = total[k][TOTAL_W-1:SHIFT];
         if (scaled[k] > $signed(SCALE_W'(cgl_pkg::OUT_MAX))) begin
            colour_in[k] = cgl_pkg::OUT_W'(cgl_pkg::OUT_MAX);
         end else if (scaled[k] < $signed(SCALE_W'(cgl_pkg::OUT_MIN))) begin
            colour_in[k] = cgl_pkg::OUT_W'(cgl_pkg::OUT_MIN);
         end else begin
            colour_in[k] = cgl_pkg::OUT_W'(scaled[k]);
         end
      end
   end

   // merge pipeline registers
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         luma_ff     <= luma_sum;
         chan6_ff    <= chan_in;
         red_idx6_ff <= index_in[0];
         row_ff      <= ROW_W'(index_in[2]) * ROW_W'(size) + ROW_W'(index_in[1]);
      end
      if (stage_en[1]) begin
         luma7_ff  <= luma_ff;
         entry7_ff <= cgl_pkg::ENTRY_W'(lin);
         for (int k = 0; k < cgl_pkg::LANES; k++) begin
            sprod_ff[k] <= SPROD_W'(diff[k]) * SPROD_W'($signed({1'b0, saturation}));
         end
      end
      if (stage_en[2]) begin
         colour_ff <= colour_in;
         entry_ff  <= entry7_ff;
      end
   end

   assign colour_out = colour_ff;
   assign entry_out  = entry_ff;

endmodule

`default_nettype wire

@@ src/color_grading_lut_entry.sv @@
// Pipeline: eight register stages between the request transfer and rsp_tvalid.
// Throughput: one LUT entry per cycle while rsp_tready is high; each stage
// moves on when its successor is empty or moving, so bubbles close up and a
// waiting result does not stop new requests while earlier stages are free.
// Reset (synchronous, active high) empties the pipeline and restores the
// register defaults: grid size 33, all gains 1.0.
`timescale 1ns / 1ps
`default_nettype none

module color_grading_lut_entry (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // red_index [5:0], green_index [11:6], blue_index [17:12], zero fill
   input  wire logic [cgl_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // red_out [15:0], green_out [31:16], blue_out [47:32], entry_index [65:48]
   output logic      [cgl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [cgl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cgl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [cgl_pkg::GRID_W-1:0]  grid_ff;
   logic [cgl_pkg::GAIN_W-1:0]  exposure_ff;
   logic [cgl_pkg::GAIN_W-1:0]  contrast_ff;
   logic [cgl_pkg::GAIN_W-1:0]  saturation_ff;
   logic [cgl_pkg::SIZE_W-1:0]  size_eff;
   logic [cgl_pkg::LAST_W-1:0]  last;
   logic [cgl_pkg::RECIP_W-1:0] recip_tab [cgl_pkg::MAX_GRID_SIZE];
   cgl_pkg::lane_cfg_type       lane_cfg;

   logic [cgl_pkg::PIPE_STAGES-1:0] valid_ff;
   logic [cgl_pkg::PIPE_STAGES-1:0] valid_in;
   logic [cgl_pkg::PIPE_STAGES-1:0] stage_en;

   logic [cgl_pkg::LANES-1:0][cgl_pkg::IDX_W-1:0] req_idx;
   logic [cgl_pkg::LANES-1:0][cgl_pkg::CH_W-1:0]  lane_chan;
   logic [cgl_pkg::LANES-1:0][cgl_pkg::IDX_W-1:0] lane_idx;
   logic [cgl_pkg::LANES-1:0][cgl_pkg::OUT_W-1:0] colour;
   logic [cgl_pkg::ENTRY_W-1:0]                   entry;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff       <= cgl_pkg::GRID_RESET;
         exposure_ff   <= cgl_pkg::GAIN_ONE;
         contrast_ff   <= cgl_pkg::GAIN_ONE;
         saturation_ff <= cgl_pkg::GAIN_ONE;
      end else if (csr_we) begin
         unique case (cgl_pkg::csr_reg_type'(csr_index))
            cgl_pkg::REG_GRID_SIZE:  grid_ff       <= cgl_pkg::GRID_W'(csr_wdata);
            cgl_pkg::REG_EXPOSURE:   exposure_ff   <= csr_wdata;
            cgl_pkg::REG_CONTRAST:   contrast_ff   <= csr_wdata;
            cgl_pkg::REG_SATURATION: saturation_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective grid size, limited to the supported range
   always_comb begin
      if (cgl_pkg::CMPG_W'(grid_ff) < cgl_pkg::CMPG_W'(2)) begin
         size_eff = cgl_pkg::SIZE_W'(2);
      end else if (cgl_pkg::CMPG_W'(grid_ff) > cgl_pkg::CMPG_W'(cgl_pkg::MAX_GRID_SIZE)) begin
         size_eff = cgl_pkg::SIZE_W'(cgl_pkg::MAX_GRID_SIZE);
      end else begin
         size_eff = cgl_pkg::SIZE_W'(grid_ff);
      end
   end

   assign last = cgl_pkg::LAST_W'(size_eff - cgl_pkg::SIZE_W'(1));

   // reciprocal table, ceil(2^RECIP_SHIFT / d) for each last position d
   for (genvar g = 0; g < cgl_pkg::MAX_GRID_SIZE; g++) begin : g_recip
      if (g == 0) begin : g_zero
         assign recip_tab[g] = '0;
      end else begin : g_entry
         localparam logic [cgl_pkg::RECIP_W-1:0] RecipValue =
            cgl_pkg::RECIP_W'(((64'd1 << cgl_pkg::RECIP_SHIFT) + g - 1) / g);
         assign recip_tab[g] = RecipValue;
      end
   end

   assign lane_cfg.last     = last;
   assign lane_cfg.recip    = recip_tab[last];
   assign lane_cfg.exposure = exposure_ff;
   assign lane_cfg.contrast = contrast_ff;

   // stage enables: a stage loads when it is empty or its content moves on
   always_comb begin
      stage_en[cgl_pkg::PIPE_STAGES-1] = !valid_ff[cgl_pkg::PIPE_STAGES-1] || rsp_tready;
      for (int k = cgl_pkg::PIPE_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // valid chain
   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int k = 1; k < cgl_pkg::PIPE_STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[cgl_pkg::PIPE_STAGES-1];

   // one lane per colour channel
   for (genvar c = 0; c < cgl_pkg::LANES; c++) begin : g_lane
      assign req_idx[c] = req_tdata[c*cgl_pkg::IDX_W +: cgl_pkg::IDX_W];

      cgl_lane u_lane (
         .clock     (clock),
         .stage_en  (stage_en[cgl_pkg::LANE_STAGES-1:0]),
         .cfg       (lane_cfg),
         .index_in  (req_idx[c]),
         .chan_out  (lane_chan[c]),
         .index_out (lane_idx[c])
      );
   end

   cgl_merge u_merge (
      .clock      (clock),
      .stage_en   (stage_en[cgl_pkg::PIPE_STAGES-1:cgl_pkg::LANE_STAGES]),
      .size       (size_eff),
      .saturation (saturation_ff),
      .chan_in    (lane_chan),
      .index_in   (lane_idx),
      .colour_out (colour),
      .entry_out  (entry)
   );

   // result packing, zero filled to whole bytes
   assign rsp_tdata = {
      (cgl_pkg::RSP_DATA_W - cgl_pkg::LANES*cgl_pkg::OUT_W - cgl_pkg::ENTRY_W)'(0),
      entry, colour[2], colour[1], colour[0]
   };

endmodule

`default_nettype wire

@@ src/cgl_checker.sv @@
// Port level checks for the colour grading LUT entry generator, bound to the
// top level. Tracks items in flight from the transfers. Depends on cgl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cgl_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic [cgl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready
);

   localparam int OCC_W = $clog2(cgl_pkg::PIPE_STAGES + 1);

   logic             req_xfer;
   logic             rsp_xfer;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // items in flight
   always_comb begin
      occ_in = occ_ff;
      if (req_xfer && !rsp_xfer) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (!req_xfer && rsp_xfer) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no result without an item in flight
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("result with no item in flight");

   // a full pipeline only takes a request when the result leaves
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      occ_ff == OCC_W'(cgl_pkg::PIPE_STAGES) && !rsp_tready |-> !req_tready)
      else $error("request taken with pipeline full");

endmodule

bind color_grading_lut_entry cgl_checker u_checker (.*);

`default_nettype wire

@@ tb/color_grading_lut_entry_test.sv @@
// Self-checking testbench for color_grading_lut_entry: grid positions go in on the req stream,
// graded colours and entry numbers are predicted and compared on the rsp stream.
// Depends on cgl_pkg and the color_grading_lut_entry top level only.
`timescale 1ns / 1ps

module color_grading_lut_entry_test;

   localparam int PIPE_LATENCY = cgl_pkg::PIPE_STAGES;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 450;
   localparam int RETUNE_EVERY = 150;

   // one graded LUT entry as it leaves the block
   typedef struct packed {
      logic signed [cgl_pkg::OUT_W-1:0] red;
      logic signed [cgl_pkg::OUT_W-1:0] green;
      logic signed [cgl_pkg::OUT_W-1:0] blue;
      logic [cgl_pkg::ENTRY_W-1:0]      entry;
   } lut_entry_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic [cgl_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [cgl_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic                             csr_we = 1'b0;
   logic [cgl_pkg::CSR_IDX_W-1:0]    csr_index = '0;
   logic [cgl_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   // local copy of the grading registers, reset values
   logic [cgl_pkg::GRID_W-1:0]       model_grid = cgl_pkg::GRID_RESET;
   logic [cgl_pkg::GAIN_W-1:0]       model_exposure = cgl_pkg::GAIN_ONE;
   logic [cgl_pkg::GAIN_W-1:0]       model_contrast = cgl_pkg::GAIN_ONE;
   logic [cgl_pkg::GAIN_W-1:0]       model_saturation = cgl_pkg::GAIN_ONE;

   lut_entry_type           graded_queue [$];
   int                      mismatch_count = 0;
   int                      entries_sent = 0;
   int                      entries_checked = 0;
   int                      settings_applied = 0;
   int                      gap_pct = 0;
   int                      stall_pct = 0;
   int                      hold_request = 0;
   int                      hold_left = 0;
   int                      watchdog_cycles;
   logic                    req_offer = 1'b0;

   color_grading_lut_entry DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // division rounding toward minus infinity
   function automatic longint floor_quot(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   // grid size as the block uses it, out-of-range writes pulled into 2..MAX
   function automatic longint effective_size();
      longint size;
      size = longint'(model_grid);
      if (size < 2) size = 2;
      else if (size > cgl_pkg::MAX_GRID_SIZE) size = longint'(cgl_pkg::MAX_GRID_SIZE);
      return size;
   endfunction

   // normalise, expose, contrast about mid grey, clamp to [0, 1.0]
   function automatic longint graded_level(longint pos, longint last);
      longint norm;
      longint lit;
      longint cont;
      norm = (pos * cgl_pkg::CH_ONE) / last;
      lit  = (norm * longint'(model_exposure)) / cgl_pkg::CH_ONE;
      cont = floor_quot((lit - cgl_pkg::MID_GREY) * longint'(model_contrast),
                        longint'(cgl_pkg::CH_ONE)) + cgl_pkg::MID_GREY;
      if (cont < 0) cont = 0;
      else if (cont > cgl_pkg::CH_ONE) cont = longint'(cgl_pkg::CH_ONE);
      return cont;
   endfunction

   // full grading of one grid position under the current registers
   function automatic lut_entry_type grade_entry(logic [cgl_pkg::IDX_W-1:0] red_pos,
                                                 logic [cgl_pkg::IDX_W-1:0] green_pos,
                                                 logic [cgl_pkg::IDX_W-1:0] blue_pos);
      longint size;
      longint last;
      longint luma;
      longint diff;
      longint v;
      longint entry_num;
      longint pos [cgl_pkg::LANES];
      longint lvl [cgl_pkg::LANES];
      logic [cgl_pkg::OUT_W-1:0] chan [cgl_pkg::LANES];
      lut_entry_type res;
      size   = effective_size();
      last   = size - 1;
      pos[0] = longint'(red_pos);
      pos[1] = longint'(green_pos);
      pos[2] = longint'(blue_pos);
      for (int k = 0; k < cgl_pkg::LANES; k++) begin
         if (pos[k] > last) pos[k] = last;
         lvl[k] = graded_level(pos[k], last);
      end
      luma = cgl_pkg::LUMA_R * lvl[0] + cgl_pkg::LUMA_G * lvl[1] + cgl_pkg::LUMA_B * lvl[2];
      // saturation pushes each channel away from luma
      for (int k = 0; k < cgl_pkg::LANES; k++) begin
         diff = lvl[k] * cgl_pkg::CH_ONE - luma;
         v = floor_quot(luma * cgl_pkg::CH_ONE + diff * longint'(model_saturation),
                        longint'(1) << 24);
         if (v < cgl_pkg::OUT_MIN) v = longint'(cgl_pkg::OUT_MIN);
         else if (v > cgl_pkg::OUT_MAX) v = longint'(cgl_pkg::OUT_MAX);
         chan[k] = v[cgl_pkg::OUT_W-1:0];
      end
      entry_num = (pos[2] * size + pos[1]) * size + pos[0];
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      res.entry = entry_num[cgl_pkg::ENTRY_W-1:0];
      return res;
   endfunction

   // index picker biased toward the grid edges and the clamped region
   function automatic logic [cgl_pkg::IDX_W-1:0] pick_index();
      longint last;
      last = effective_size() - 1;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return cgl_pkg::IDX_W'(last);
         3, 4, 5: return cgl_pkg::IDX_W'($urandom_range(0, int'(last)));
         default: return cgl_pkg::IDX_W'($urandom_range(0, 63));
      endcase
   endfunction

   function automatic logic [cgl_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return cgl_pkg::GAIN_ONE;
         3, 4: return cgl_pkg::GAIN_W'($urandom_range(2048, 8192));
         default: return cgl_pkg::GAIN_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [cgl_pkg::GRID_W-1:0] pick_grid();
      case ($urandom_range(0, 9))
         0: return cgl_pkg::GRID_W'($urandom_range(0, 1));
         1: return cgl_pkg::GRID_W'($urandom_range(cgl_pkg::MAX_GRID_SIZE + 1, 127));
         2: return cgl_pkg::GRID_W'(2);
         3: return cgl_pkg::GRID_W'(cgl_pkg::MAX_GRID_SIZE);
         4, 5: return cgl_pkg::GRID_W'($urandom_range(2, 8));
         default: return cgl_pkg::GRID_W'($urandom_range(2, cgl_pkg::MAX_GRID_SIZE));
      endcase
   endfunction

   // offer one grid position and wait for its transfer
   task automatic send_entry(input logic [cgl_pkg::IDX_W-1:0] red_pos,
                             input logic [cgl_pkg::IDX_W-1:0] green_pos,
                             input logic [cgl_pkg::IDX_W-1:0] blue_pos);
      while ($urandom_range(0, 99) < gap_pct) begin
         if (req_offer) begin
            req_tvalid <= 1'b0;
            req_offer = 1'b0;
         end
         @(posedge clock);
      end
      req_tdata  <= {{(cgl_pkg::REQ_DATA_W - 3 * cgl_pkg::IDX_W){1'b0}},
                     blue_pos, green_pos, red_pos};
      req_tvalid <= 1'b1;
      req_offer = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      graded_queue.push_back(grade_entry(red_pos, green_pos, blue_pos));
      entries_sent++;
   endtask

   // stop offering and wait until every predicted entry has come back
   task automatic wait_results_drained();
      if (req_offer) begin
         req_tvalid <= 1'b0;
         req_offer = 1'b0;
      end
      while (graded_queue.size() != 0) @(posedge clock);
   endtask

   // reprogram all four registers while the pipeline is empty
   task automatic apply_settings(input logic [cgl_pkg::GRID_W-1:0] grid,
                                 input logic [cgl_pkg::GAIN_W-1:0] exposure,
                                 input logic [cgl_pkg::GAIN_W-1:0] contrast,
                                 input logic [cgl_pkg::GAIN_W-1:0] saturation);
      cgl_pkg::csr_reg_type reg_sel;
      logic [cgl_pkg::CSR_DATA_W-1:0] value;
      wait_results_drained();
      repeat (PIPE_LATENCY) @(posedge clock);
      for (int k = 0; k < 4; k++) begin
         reg_sel = cgl_pkg::csr_reg_type'(k);
         case (reg_sel)
            cgl_pkg::REG_GRID_SIZE:
               value = {(cgl_pkg::CSR_DATA_W - cgl_pkg::GRID_W)'($urandom), grid};
            cgl_pkg::REG_EXPOSURE:   value = exposure;
            cgl_pkg::REG_CONTRAST:   value = contrast;
            cgl_pkg::REG_SATURATION: value = saturation;
         endcase
         csr_we    <= 1'b1;
         csr_index <= reg_sel;
         csr_wdata <= value;
         @(posedge clock);
         case (reg_sel)
            cgl_pkg::REG_GRID_SIZE:  model_grid = value[cgl_pkg::GRID_W-1:0];
            cgl_pkg::REG_EXPOSURE:   model_exposure = value;
            cgl_pkg::REG_CONTRAST:   model_contrast = value;
            cgl_pkg::REG_SATURATION: model_saturation = value;
         endcase
      end
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic report_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // result checker, oldest prediction first
   always @(posedge clock) begin
      lut_entry_type got;
      lut_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red   = rsp_tdata[15:0];
         got.green = rsp_tdata[31:16];
         got.blue  = rsp_tdata[47:32];
         got.entry = rsp_tdata[65:48];
         if (graded_queue.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
         end else begin
            want = graded_queue.pop_front();
            report_field("red_out", longint'(want.red), longint'(got.red));
            report_field("green_out", longint'(want.green), longint'(got.green));
            report_field("blue_out", longint'(want.blue), longint'(got.blue));
            report_field("entry_index", longint'(want.entry), longint'(got.entry));
            entries_checked++;
         end
      end
   end

   // result side ready, random stalls plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog
   initial begin
      for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
         @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // reset values: grid 33, unity gains, indices past the grid clamp
   task automatic test_default_grid();
      send_entry(6'd0, 6'd0, 6'd0);
      send_entry(6'd32, 6'd32, 6'd32);
      send_entry(6'd63, 6'd63, 6'd63);
      send_entry(6'd32, 6'd0, 6'd63);
      send_entry(6'd16, 6'd8, 6'd24);
      send_entry(6'd33, 6'd34, 6'd35);
   endtask

   // grid sizes below 2, at the maximum and above it
   task automatic test_grid_clamping();
      apply_settings(7'd0, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE);
      send_entry(6'd0, 6'd0, 6'd0);
      send_entry(6'd1, 6'd63, 6'd1);
      apply_settings(7'd1, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE);
      send_entry(6'd63, 6'd0, 6'd63);
      apply_settings(7'd127, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE);
      send_entry(6'd63, 6'd62, 6'd61);
      send_entry(6'd0, 6'd63, 6'd0);
      apply_settings(7'd64, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE);
      send_entry(6'd63, 6'd63, 6'd63);
      send_entry(6'd1, 6'd2, 6'd3);
      apply_settings(7'd65, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE);
      send_entry(6'd40, 6'd63, 6'd10);
   endtask

   // gains at zero and full scale, saturation driving outputs to both rails
   task automatic test_gain_extremes();
      apply_settings(7'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_entry(6'd63, 6'd0, 6'd31);
      send_entry(6'd10, 6'd20, 6'd30);
      apply_settings(7'd64, 16'h0000, 16'h0000, 16'h0000);
      send_entry(6'd63, 6'd63, 6'd63);
      apply_settings(7'd17, cgl_pkg::GAIN_ONE, 16'hFFFF, 16'h0000);
      send_entry(6'd0, 6'd63, 6'd20);
      apply_settings(7'd40, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_entry(6'd5, 6'd60, 6'd33);
      apply_settings(7'd64, cgl_pkg::GAIN_ONE, cgl_pkg::GAIN_ONE, 16'hFFFF);
      send_entry(6'd63, 6'd0, 6'd0);
      send_entry(6'd0, 6'd63, 6'd63);
   endtask

   // random entries under a given traffic shape, registers retuned now and then
   task automatic run_random_phase(input int gap, input int stall);
      gap_pct   = gap;
      stall_pct = stall;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i % RETUNE_EVERY == 0)
            apply_settings(pick_grid(), pick_gain(), pick_gain(), pick_gain());
         send_entry(pick_index(), pick_index(), pick_index());
      end
   endtask

   task automatic test_free_running();
      run_random_phase(0, 0);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(56, 0);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(0, 56);
   endtask

   task automatic test_both_idle();
      run_random_phase(29, 29);
   endtask

   // long result hold-off while requests keep coming, so the pipe backs up
   task automatic test_output_hold_off();
      gap_pct   = 0;
      stall_pct = 0;
      hold_request = 300;
      for (int i = 0; i < 60; i++)
         send_entry(pick_index(), pick_index(), pick_index());
   endtask

   // sender pauses mid-stream until the pipe has emptied
   task automatic test_sender_pause();
      gap_pct   = 0;
      stall_pct = 29;
      for (int i = 0; i < 25; i++)
         send_entry(pick_index(), pick_index(), pick_index());
      wait_results_drained();
      for (int i = 0; i < 25; i++)
         send_entry(pick_index(), pick_index(), pick_index());
   endtask

   // test sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_grid();
      test_grid_clamping();
      test_gain_extremes();
      test_free_running();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_output_hold_off();
      test_sender_pause();
      wait_results_drained();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      $display("graded %0d LUT entries, %0d checked, over %0d register settings",
               entries_sent, entries_checked, settings_applied);
      $display("grid sizes clamped both ways, gain extremes, idle, stall and hold-off traffic");
      if (mismatch_count == 0 && graded_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/cgl_pkg.sv
src/cgl_lane.sv
src/cgl_merge.sv
src/color_grading_lut_entry.sv
src/cgl_checker.sv
tb/color_grading_lut_entry_test.sv
